[rtl/plst_pkg.sv]
`default_nettype none
package plst_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 4;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_POINTS = '0;

    // item operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // table read address select
    localparam logic [1:0] RD_LAST = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_CUR  = 2'd2;

    // serial divider step counts
    localparam int DIV_CNT_W       = 7;
    localparam int DIV_STEPS_LONG  = 64;
    localparam int DIV_STEPS_SHORT = 32;

    typedef struct packed {
        logic       load_wr;
        logic       capture;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_next;
        logic       cap_seg;
        logic       inc_i;
        logic       mul_en;
        logic       div_start;
        logic       div_short;
        logic       wrap_done;
        logic       set_empty;
        logic       set_hold;
        logic       set_v0;
        logic       set_quot;
        logic       push_out;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic total_zero;
        logic t_gt_rd;
        logic seg_more;
        logic dt_zero;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[rtl/plst_if.sv]
`default_nettype none
interface plst_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [plst_pkg::IDX_W-1:0]        entry_index;
    logic [plst_pkg::DATA_W-1:0]       entry_time;
    logic signed [plst_pkg::DATA_W-1:0] entry_value;
    logic [plst_pkg::DATA_W-1:0]       query_time;

    modport source (
        output valid, op, entry_index, entry_time, entry_value, query_time,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, entry_time, entry_value, query_time,
        output ready
    );
endinterface

interface plst_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [plst_pkg::DATA_W-1:0] setpoint;
    logic                              table_empty;

    modport source (
        output valid, setpoint, table_empty,
        input  ready
    );
    modport sink (
        input  valid, setpoint, table_empty,
        output ready
    );
endinterface
`default_nettype wire

[rtl/plst_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module plst_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_short,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_busy,
    output logic [63:0]      o_quot,
    output logic [31:0]      o_rem
);

    logic [plst_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_div;
    logic [32:0] w_sh;
    logic [32:0] w_diff;

    always_comb begin
        w_sh   = {r_rem, r_quo[63]};
        w_diff = w_sh - {1'b0, r_div};
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_cnt = i_short ? plst_pkg::DIV_CNT_W'(plst_pkg::DIV_STEPS_SHORT)
                            : plst_pkg::DIV_CNT_W'(plst_pkg::DIV_STEPS_LONG);
            n_quo = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - plst_pkg::DIV_CNT_W'(1);
            if (!w_diff[32]) begin
                n_rem = w_diff[31:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_sh[31:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

[rtl/plst_ctrl.sv]
`default_nettype none
module plst_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_op,
    output logic                   o_ready,
    input  wire plst_pkg::t_status i_status,
    output plst_pkg::t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LAST    = 4'd1;
    localparam logic [3:0] S_TOTAL   = 4'd2;
    localparam logic [3:0] S_WRAP    = 4'd3;
    localparam logic [3:0] S_SCANRD  = 4'd4;
    localparam logic [3:0] S_SCANCMP = 4'd5;
    localparam logic [3:0] S_SEG     = 4'd6;
    localparam logic [3:0] S_MUL     = 4'd7;
    localparam logic [3:0] S_DIVGO   = 4'd8;
    localparam logic [3:0] S_QWAIT   = 4'd9;
    localparam logic [3:0] S_HOLD    = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == plst_pkg::OP_QUERY) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_LAST;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_LAST: begin
                if (i_status.n_zero) begin
                    o_cmd.set_empty = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = plst_pkg::RD_LAST;
                    n_state      = S_TOTAL;
                end
            end
            S_TOTAL: begin
                if (i_status.total_zero) begin
                    o_cmd.set_empty = 1'b1;
                    n_state         = S_DONE;
                end else if (i_status.t_gt_rd) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_short = 1'b1;
                    n_state         = S_WRAP;
                end else begin
                    n_state = S_SCANRD;
                end
            end
            S_WRAP: begin
                if (!i_status.div_busy) begin
                    o_cmd.wrap_done = 1'b1;
                    n_state         = S_SCANRD;
                end
            end
            S_SCANRD: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.seg_more) begin
                    o_cmd.rd_sel = plst_pkg::RD_NEXT;
                    n_state      = S_SCANCMP;
                end else begin
                    o_cmd.rd_sel = plst_pkg::RD_LAST;
                    n_state      = S_HOLD;
                end
            end
            S_SCANCMP: begin
                if (i_status.t_gt_rd) begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = S_SCANRD;
                end else begin
                    o_cmd.cap_next = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = plst_pkg::RD_CUR;
                    n_state        = S_SEG;
                end
            end
            S_SEG: begin
                o_cmd.cap_seg = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                if (i_status.dt_zero) begin
                    o_cmd.set_v0 = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.mul_en = 1'b1;
                    n_state      = S_DIVGO;
                end
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_QWAIT;
            end
            S_QWAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.set_quot = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_HOLD: begin
                o_cmd.set_hold = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.push_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[rtl/plst_dp.sv]
`default_nettype none
module plst_dp #(
    parameter int MAX_POINTS = plst_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire plst_pkg::t_cmd                i_cmd,
    output plst_pkg::t_status                  o_status,
    input  wire logic [plst_pkg::CFG_W-1:0]    i_points,
    input  wire logic [plst_pkg::IDX_W-1:0]    i_entry_index,
    input  wire logic [plst_pkg::DATA_W-1:0]   i_entry_time,
    input  wire logic [plst_pkg::DATA_W-1:0]   i_entry_value,
    input  wire logic [plst_pkg::DATA_W-1:0]   i_query_time,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [plst_pkg::DATA_W-1:0]        o_setpoint,
    output logic                               o_table_empty
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int DW = plst_pkg::DATA_W;

    function automatic logic [DW-1:0] mag33(input logic [DW:0] a);
        logic [DW:0] m;
        m = a[DW] ? (~a + (DW+1)'(1)) : a;
        return m[DW-1:0];
    endfunction

    // breakpoint tables
    logic [DW-1:0] r_time_mem  [MAX_POINTS];
    logic [DW-1:0] r_value_mem [MAX_POINTS];
    logic [DW-1:0] r_rd_time, r_rd_value;

    logic [IW-1:0] w_wr_addr, w_rd_addr;
    logic          w_idx_ok;
    logic [NW-1:0] w_n_eff;

    logic [NW-1:0] r_n;
    logic [IW-1:0] r_i;
    logic [DW-1:0] r_t;
    logic [DW-1:0] r_t1, r_v1, r_v0;
    logic [DW-1:0] r_mdx, r_mdv, r_mdt;
    logic          r_neg, r_dt_zero;
    logic [63:0]   r_prod;
    logic [DW-1:0] r_res;
    logic          r_empty;
    logic          r_out_valid;
    logic [DW-1:0] r_out_sp;
    logic          r_out_empty;

    logic [DW:0]   w_dt, w_dx, w_dv;
    logic          w_div_busy;
    logic [63:0]   w_div_quot;
    logic [DW-1:0] w_div_rem;
    logic [63:0]   w_dividend;
    logic [DW-1:0] w_divisor;
    logic [33:0]   w_qc;
    logic [34:0]   w_sum;
    logic [DW-1:0] w_sat;

    assign w_idx_ok  = 32'(i_entry_index) < 32'(MAX_POINTS);
    assign w_wr_addr = IW'(i_entry_index);
    assign w_n_eff   = (32'(i_points) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(i_points);

    always_comb begin
        case (i_cmd.rd_sel)
            plst_pkg::RD_LAST: w_rd_addr = IW'(r_n - NW'(1));
            plst_pkg::RD_NEXT: w_rd_addr = r_i + IW'(1);
            default:           w_rd_addr = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && w_idx_ok) begin
            r_time_mem[w_wr_addr]  <= i_entry_time;
            r_value_mem[w_wr_addr] <= i_entry_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_time  <= r_time_mem[w_rd_addr];
            r_rd_value <= r_value_mem[w_rd_addr];
        end
    end

    // segment differences: t0/v0 sit in the read registers during cap_seg
    assign w_dt = {1'b0, r_t1} - {1'b0, r_rd_time};
    assign w_dx = {1'b0, r_t} - {1'b0, r_rd_time};
    assign w_dv = {r_v1[DW-1], r_v1} - {r_rd_value[DW-1], r_rd_value};

    // wrap: ((t-1) mod total) via 32 steps on {t-1, 0}
    assign w_dividend = i_cmd.div_short ? {r_t - DW'(1), 32'd0} : r_prod;
    assign w_divisor  = i_cmd.div_short ? r_rd_time : r_mdt;

    plst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_short    (i_cmd.div_short),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // quotient clamp at 2^33, then signed add and saturate
    always_comb begin
        if ((w_div_quot[63:34] != '0) || (w_div_quot[33] && (w_div_quot[32:0] != '0))) begin
            w_qc = {1'b1, 33'd0};
        end else begin
            w_qc = w_div_quot[33:0];
        end
        if (r_neg) begin
            w_sum = {{3{r_v0[DW-1]}}, r_v0} - {1'b0, w_qc};
        end else begin
            w_sum = {{3{r_v0[DW-1]}}, r_v0} + {1'b0, w_qc};
        end
        if (!w_sum[34] && (w_sum[33:31] != 3'b000)) begin
            w_sat = {1'b0, {(DW-1){1'b1}}};
        end else if (w_sum[34] && (w_sum[33:31] != 3'b111)) begin
            w_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_sat = w_sum[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_t <= i_query_time;
            r_n <= w_n_eff;
            r_i <= '0;
        end else begin
            if (i_cmd.wrap_done) begin
                r_t <= w_div_rem + DW'(1);
            end
            if (i_cmd.inc_i) begin
                r_i <= r_i + IW'(1);
            end
        end
        if (i_cmd.cap_next) begin
            r_t1 <= r_rd_time;
            r_v1 <= r_rd_value;
        end
        if (i_cmd.cap_seg) begin
            r_mdx     <= mag33(w_dx);
            r_mdv     <= mag33(w_dv);
            r_mdt     <= mag33(w_dt);
            r_neg     <= w_dx[DW] ^ w_dv[DW] ^ w_dt[DW];
            r_dt_zero <= (w_dt == '0);
            r_v0      <= r_rd_value;
        end
        if (i_cmd.mul_en) begin
            r_prod <= 64'(r_mdx) * 64'(r_mdv);
        end
        if (i_cmd.set_empty) begin
            r_res   <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.set_hold) begin
            r_res   <= r_rd_value;
            r_empty <= 1'b0;
        end else if (i_cmd.set_v0) begin
            r_res   <= r_v0;
            r_empty <= 1'b0;
        end else if (i_cmd.set_quot) begin
            r_res   <= w_sat;
            r_empty <= 1'b0;
        end
        if (i_cmd.push_out) begin
            r_out_sp    <= r_res;
            r_out_empty <= r_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.n_zero     = (r_n == '0);
    assign o_status.total_zero = (r_rd_time == '0);
    assign o_status.t_gt_rd    = (r_t > r_rd_time);
    assign o_status.seg_more   = ((NW'(r_i) + NW'(1)) < r_n);
    assign o_status.dt_zero    = r_dt_zero;
    assign o_status.div_busy   = w_div_busy;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_setpoint    = r_out_sp;
    assign o_table_empty = r_out_empty;

endmodule
`default_nettype wire

[rtl/piecewise_linear_setpoint_table.sv]
// Load transaction: table written at the accept edge, no result.
// Query transaction: the time from accept to result grows with k = segments passed in
//   the scan, and a wrap divide adds to it; the 64-step serial divider dominates.
// One item in work at a time; a finished result waits in the output register while the
//   next item is taken. Synchronous active-low reset clears points_in_use, the FSM and the
//   output valid; the breakpoint tables are not cleared and are undefined until loaded.
`default_nettype none
module piecewise_linear_setpoint_table #(
    parameter int MAX_POINTS = plst_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    plst_in_if.sink                            i_in,
    plst_out_if.source                         o_out,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [plst_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [plst_pkg::PDATA_W-1:0]  pwdata,
    output logic [plst_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // Configuration: one register, points_in_use, at byte address 0.
    // Written in the APB access phase; pready is tied high (no waits).
    // ------------------------------------------------------------------
    logic [plst_pkg::CFG_W-1:0]     r_points;
    logic [plst_pkg::PADDR_W-3:0]   w_reg_idx;
    logic                           w_apb_wr;

    assign w_reg_idx = paddr[plst_pkg::PADDR_W-1:2];
    assign w_apb_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= '0;
        end else if (w_apb_wr && (w_reg_idx == plst_pkg::REG_POINTS)) begin
            r_points <= pwdata[plst_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (w_reg_idx == plst_pkg::REG_POINTS)
                  ? {{(plst_pkg::PDATA_W-plst_pkg::CFG_W){1'b0}}, r_points}
                  : '0;

    // ------------------------------------------------------------------
    // Controller / datapath split. The controller sequences a query:
    //   fetch last time -> optional wrap divide -> segment scan (one
    //   table read per step) -> differences -> multiply -> 64-bit divide -> clamp/saturate
    //   -> output register; early exits for empty table, last point, zero-length segment.
    // The datapath owns the tables, the scan index, the shared divider
    // and the output register.
    // ------------------------------------------------------------------
    plst_pkg::t_cmd    w_cmd;
    plst_pkg::t_status w_status;
    logic [plst_pkg::DATA_W-1:0] w_setpoint;

    plst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_op     (i_in.op),
        .o_ready  (i_in.ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    plst_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_points      (r_points),
        .i_entry_index (i_in.entry_index),
        .i_entry_time  (i_in.entry_time),
        .i_entry_value (i_in.entry_value),
        .i_query_time  (i_in.query_time),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_setpoint    (w_setpoint),
        .o_table_empty (o_out.table_empty)
    );

    // result transaction payload
    assign o_out.setpoint = w_setpoint;

endmodule
`default_nettype wire
